@@ hdl/fern_forest_posterior_update_core_macros.svh @@
// Assertion macros for the fern forest core
`ifndef FERN_FOREST_POSTERIOR_UPDATE_CORE_MACROS_SVH
`define FERN_FOREST_POSTERIOR_UPDATE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FF_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define FF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/ffpu_pkg.sv @@
// Shared types and constants of the fern forest core
`timescale 1ns / 1ps
package ffpu_pkg;
   localparam int MAX_TREES = 10;
   localparam int FIELD_BITS = 13;
   localparam int VOTE_BITS = 20;
   localparam logic [0:0] OP_EVALUATE = 1'b0;
   localparam logic [0:0] OP_TRAIN = 1'b1;
   localparam logic [0:0] REG_POS_THRESHOLD = 1'b0;
   localparam logic [0:0] REG_NEG_THRESHOLD = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic       label;
      logic [FIELD_BITS-1:0] code_tree9;
      logic [FIELD_BITS-1:0] code_tree8;
      logic [FIELD_BITS-1:0] code_tree7;
      logic [FIELD_BITS-1:0] code_tree6;
      logic [FIELD_BITS-1:0] code_tree5;
      logic [FIELD_BITS-1:0] code_tree4;
      logic [FIELD_BITS-1:0] code_tree3;
      logic [FIELD_BITS-1:0] code_tree2;
      logic [FIELD_BITS-1:0] code_tree1;
      logic [FIELD_BITS-1:0] code_tree0;
   } req_type;

   typedef struct packed {
      logic [VOTE_BITS-1:0] vote_sum;
      logic                 did_update;
   } rsp_type;
endpackage

@@ hdl/ffpu_divider.sv @@
// Restoring divider for the posterior weight, one quotient bit per cycle
`timescale 1ns / 1ps
module ffpu_divider #(
   parameter int COUNT_BITS = 16,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [COUNT_BITS-1:0]         pos,
   input  logic [COUNT_BITS-1:0]         neg,
   output logic                          done,
   output logic [WEIGHT_FRAC_BITS:0]     quotient
);
   localparam int QB = WEIGHT_FRAC_BITS + 1;
   localparam int RB = COUNT_BITS + 2;
   localparam int CB = $clog2(QB + 1);

   logic [RB-1:0]  rem_ff, rem_in, trial;
   logic [RB-1:0]  den_ff, den_in;
   logic [QB-1:0]  quo_ff, quo_in;
   logic [CB-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in, done_ff, done_in;

   // quotient of pos*2^F/(pos+neg) fits F+1 bits since pos <= total
   always_comb begin
      rem_in = rem_ff; den_in = den_ff; quo_in = quo_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = '0;
      if (start) begin
         rem_in = {2'b00, pos};
         den_in = RB'({1'b0, pos}) + RB'({1'b0, neg});
         quo_in = '0;
         cnt_in = CB'(QB);
         busy_in = (pos != '0);
         done_in = (pos == '0);
      end else if (busy_ff) begin
         // first step compares pos itself, then shift in zeros
         trial = (cnt_ff == CB'(QB)) ? rem_ff : {rem_ff[RB-2:0], 1'b0};
         if (trial >= den_ff) begin
            rem_in = trial - den_ff;
            quo_in = {quo_ff[QB-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[QB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CB'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; den_ff <= den_in; quo_ff <= quo_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

@@ hdl/fern_forest_posterior_update_core.sv @@
// Top level: fern tables in memory, sequencer for vote and update
// Sequence: read and sum the tree weights, then decide; a train with update then visits each tree
// in turn to read, divide and write back its entry, the divide ending early where pos is zero.
// Throughput: one transaction at a time; busy is high from acceptance to the result strobe.
// Cost is set by the one table memory with one read and one write port and the shared bit-serial divider.
// Reset: synchronous; a clearing pass that zeroes every table entry follows, busy stays high.
// The result is shown for one cycle on rsp_valid; the receiver cannot stall.
`timescale 1ns / 1ps
module fern_forest_posterior_update_core #(
   parameter int TREES = 10,
   parameter int CODE_BITS = 13,
   parameter int COUNT_BITS = 16,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ffpu_pkg::req_type   req_data,
   output logic                rsp_valid,
   output ffpu_pkg::rsp_type   rsp_data,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [19:0]         csr_data
);
   import ffpu_pkg::*;
`include "fern_forest_posterior_update_core_macros.svh"

   localparam int WB = WEIGHT_FRAC_BITS + 1;
   localparam int EB = 2 * COUNT_BITS + WB;
   localparam int TB = (TREES > 1) ? $clog2(TREES) : 1;
   localparam int AB = TB + CODE_BITS;
   localparam int DEPTH = TREES << CODE_BITS;
   localparam int SB = WB + 4;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_SUM, S_DECIDE, S_UREAD, S_UWAIT, S_UDIV,
      S_UWRITE, S_DONE
   } state_type;

   // entry layout: {pos, neg, weight}
   logic [EB-1:0] table_mem [DEPTH];
   logic [EB-1:0] rdata_ff;
   logic          we;
   logic [AB-1:0] waddr, raddr;
   logic [EB-1:0] wdata;

   always_ff @(posedge clock) begin
      if (we) table_mem[waddr] <= wdata;
      rdata_ff <= table_mem[raddr];
   end

   state_type          state_ff;
   logic [CODE_BITS-1:0] clr_ff;
   logic [TB-1:0]      tree_ff;
   logic               rvld_ff;
   logic [SB-1:0]      sum_ff;
   logic [19:0]        vote_ff;
   logic               upd_ff, lab_ff, op_ff;
   req_type            req_ff;
   logic [19:0]        pthr_ff, nthr_ff;
   logic [COUNT_BITS-1:0] pos_ff, neg_ff;
   logic [COUNT_BITS-1:0] pos_in_c, neg_in_c;
   logic               dstart;
   logic               ddone;
   logic [WB-1:0]      dq;
   logic               rsp_valid_ff;
   logic [CODE_BITS-1:0] code_sel;
   logic [FIELD_BITS*MAX_TREES-1:0] codes;

   assign codes = {req_ff.code_tree9, req_ff.code_tree8, req_ff.code_tree7,
                   req_ff.code_tree6, req_ff.code_tree5, req_ff.code_tree4,
                   req_ff.code_tree3, req_ff.code_tree2, req_ff.code_tree1,
                   req_ff.code_tree0};
   always_comb begin
      code_sel = CODE_BITS'(codes[FIELD_BITS*tree_ff +: FIELD_BITS]);
   end

   logic [AB-1:0] cur_addr;
   assign cur_addr = AB'(tree_ff) * AB'(1 << CODE_BITS) + AB'(code_sel);

   always_comb begin
      raddr = cur_addr;
      we = 1'b0;
      waddr = cur_addr;
      wdata = {pos_ff, neg_ff, dq};
      if (state_ff == S_CLEAR) begin
         we = 1'b1;
         waddr = AB'(tree_ff) * AB'(1 << CODE_BITS) + AB'(clr_ff);
         wdata = '0;
      end else if (state_ff == S_UWRITE) begin
         we = 1'b1;
      end
   end

   assign dstart = (state_ff == S_UWAIT);

   ffpu_divider #(.COUNT_BITS(COUNT_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(dstart), .pos(pos_in_c), .neg(neg_in_c),
      .done(ddone), .quotient(dq)
   );

   logic [19:0] vote_sat;
   assign vote_sat = (sum_ff > SB'(20'hFFFFF)) ? 20'hFFFFF : 20'(sum_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         tree_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pthr_ff <= 20'd327680;
         nthr_ff <= 20'd327680;
         rvld_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         rvld_ff <= 1'b0;
         if (csr_write) begin
            if (csr_index == REG_POS_THRESHOLD) pthr_ff <= csr_data;
            else pthr_ff <= pthr_ff;
            if (csr_index == REG_NEG_THRESHOLD) nthr_ff <= csr_data;
         end
         case (state_ff)
            S_CLEAR: begin
               if (clr_ff == '1) begin
                  clr_ff <= '0;
                  if (tree_ff == TB'(TREES - 1)) begin
                     tree_ff <= '0;
                     state_ff <= S_IDLE;
                  end else tree_ff <= tree_ff + 1'b1;
               end else clr_ff <= clr_ff + 1'b1;
            end
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_data;
                  op_ff <= req_data.opcode;
                  lab_ff <= req_data.label;
                  tree_ff <= '0;
                  sum_ff <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               // issue reads, accumulate each read in the cycle after it is issued
               rvld_ff <= 1'b1;
               if (rvld_ff) sum_ff <= sum_ff + SB'(rdata_ff[WB-1:0]);
               if (tree_ff == TB'(TREES - 1)) state_ff <= S_SUM;
               else tree_ff <= tree_ff + 1'b1;
            end
            S_SUM: begin
               sum_ff <= sum_ff + SB'(rdata_ff[WB-1:0]);
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               vote_ff <= vote_sat;
               upd_ff <= (op_ff == OP_TRAIN) &&
                         (lab_ff ? (vote_sat <= pthr_ff) : (vote_sat >= nthr_ff));
               tree_ff <= '0;
               if ((op_ff == OP_TRAIN) &&
                   (lab_ff ? (vote_sat <= pthr_ff) : (vote_sat >= nthr_ff)))
                  state_ff <= S_UREAD;
               else state_ff <= S_DONE;
            end
            S_UREAD: state_ff <= S_UWAIT;
            S_UWAIT: state_ff <= S_UDIV;
            S_UDIV: begin
               if (ddone) state_ff <= S_UWRITE;
            end
            S_UWRITE: begin
               if (tree_ff == TB'(TREES - 1)) state_ff <= S_DONE;
               else begin
                  tree_ff <= tree_ff + 1'b1;
                  state_ff <= S_UREAD;
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // bump the counts as the entry arrives; divider starts the same cycle
   logic [COUNT_BITS-1:0] rpos, rneg;
   assign rpos = rdata_ff[EB-1 -: COUNT_BITS];
   assign rneg = rdata_ff[EB-COUNT_BITS-1 -: COUNT_BITS];
   always_comb begin
      pos_in_c = rpos;
      neg_in_c = rneg;
      if (lab_ff) pos_in_c = (rpos == CMAX) ? rpos : rpos + 1'b1;
      else neg_in_c = (rneg == CMAX) ? rneg : rneg + 1'b1;
   end
   always_ff @(posedge clock) begin
      if (state_ff == S_UWAIT) begin
         pos_ff <= pos_in_c;
         neg_ff <= neg_in_c;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.vote_sum = vote_ff;
   assign rsp_data.did_update = upd_ff;

   `FF_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "no busy after accept")
   `FF_ASSERT_IMPL(a_rsp_from_done, clock, reset, rsp_valid, $past(state_ff) == S_DONE, "stray response")
   `FF_ASSERT_IMPL(a_write_upd, clock, reset, state_ff == S_UWRITE, upd_ff, "write without update")
endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the fern forest vote and posterior update core
`timescale 1ns / 1ps
module tb_top;
   import ffpu_pkg::*;

   localparam int TREE_COUNT = 10;
   localparam int TABLE_DEPTH = 8192;
   localparam int FRAC = 16;
   localparam int COUNT_LIMIT = 65535;
   localparam int STALL_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic csr_index = 1'b0;
   logic [19:0] csr_data = '0;

   fern_forest_posterior_update_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mirror of the fern tables and thresholds
   int unsigned pos_count [TREE_COUNT][TABLE_DEPTH];
   int unsigned neg_count [TREE_COUNT][TABLE_DEPTH];
   int unsigned weight [TREE_COUNT][TABLE_DEPTH];
   int unsigned pos_thresh = 327680;
   int unsigned neg_thresh = 327680;

   rsp_type expected_votes [$];
   int error_count = 0;
   int idle_cycles = 0;
   logic [12:0] code_pool [TREE_COUNT][8];

   function automatic req_type make_item(logic op, logic lbl, logic [12:0] c [TREE_COUNT]);
      req_type r;
      r.opcode = op;
      r.label = lbl;
      r.code_tree0 = c[0]; r.code_tree1 = c[1]; r.code_tree2 = c[2];
      r.code_tree3 = c[3]; r.code_tree4 = c[4]; r.code_tree5 = c[5];
      r.code_tree6 = c[6]; r.code_tree7 = c[7]; r.code_tree8 = c[8];
      r.code_tree9 = c[9];
      return r;
   endfunction

   // Work out the vote and apply any count update to the mirror
   function automatic rsp_type vote_and_train(req_type r);
      int unsigned c [TREE_COUNT];
      longint unsigned vote;
      longint unsigned p;
      longint unsigned n;
      logic upd;
      rsp_type res;
      c = '{r.code_tree0, r.code_tree1, r.code_tree2, r.code_tree3, r.code_tree4,
            r.code_tree5, r.code_tree6, r.code_tree7, r.code_tree8, r.code_tree9};
      vote = 0;
      for (int t = 0; t < TREE_COUNT; t++) vote += weight[t][c[t]];
      if (vote > 20'hFFFFF) vote = 20'hFFFFF;
      upd = 1'b0;
      if (r.opcode == OP_TRAIN)
         upd = r.label ? (vote <= pos_thresh) : (vote >= neg_thresh);
      if (upd) begin
         for (int t = 0; t < TREE_COUNT; t++) begin
            if (r.label) begin
               if (pos_count[t][c[t]] < COUNT_LIMIT) pos_count[t][c[t]]++;
            end else begin
               if (neg_count[t][c[t]] < COUNT_LIMIT) neg_count[t][c[t]]++;
            end
            p = pos_count[t][c[t]];
            n = neg_count[t][c[t]];
            weight[t][c[t]] = (p == 0) ? 32'd0 : 32'((p << FRAC) / (p + n));
         end
      end
      res.vote_sum = vote[19:0];
      res.did_update = upd;
      return res;
   endfunction

   // Send one transaction after a random idle once busy is low
   task automatic send_item(req_type r);
      @(negedge clock);
      while (busy) @(negedge clock);
      repeat ($urandom_range(0, 3)) @(negedge clock);
      start = 1'b1;
      req_data = r;
      @(posedge clock);
      expected_votes.push_back(vote_and_train(r));
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic wait_idle();
      while (expected_votes.size() != 0) @(posedge clock);
      @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_thresholds(logic [19:0] pos_val, logic [19:0] neg_val);
      wait_idle();
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = REG_POS_THRESHOLD;
      csr_data = pos_val;
      @(negedge clock);
      csr_index = REG_NEG_THRESHOLD;
      csr_data = neg_val;
      @(negedge clock);
      csr_write = 1'b0;
      pos_thresh = 32'(pos_val);
      neg_thresh = 32'(neg_val);
   endtask

   task automatic send_uniform(logic op, logic lbl, logic [12:0] code);
      logic [12:0] c [TREE_COUNT];
      foreach (c[t]) c[t] = code;
      send_item(make_item(op, lbl, c));
   endtask

   // Full weights, half weights, both threshold conditions and the code extremes
   task automatic test_directed();
      send_uniform(OP_EVALUATE, 1'b1, 13'd0);
      send_uniform(OP_TRAIN, 1'b1, 13'd0);
      send_uniform(OP_EVALUATE, 1'b0, 13'd0);
      send_uniform(OP_TRAIN, 1'b1, 13'd0);
      send_uniform(OP_TRAIN, 1'b0, 13'd0);
      send_uniform(OP_TRAIN, 1'b0, 13'd0);
      send_uniform(OP_EVALUATE, 1'b1, 13'd0);
      send_uniform(OP_TRAIN, 1'b0, 13'h1FFF);
      send_uniform(OP_TRAIN, 1'b1, 13'h1FFF);
      send_uniform(OP_TRAIN, 1'b1, 13'h1FFF);
      send_uniform(OP_EVALUATE, 1'b0, 13'h1FFF);
      send_uniform(OP_TRAIN, 1'b1, 13'h0AAA);
      send_uniform(OP_TRAIN, 1'b0, 13'h1555);
      write_thresholds(20'd0, 20'd655360);
      send_uniform(OP_TRAIN, 1'b1, 13'd0);
      send_uniform(OP_TRAIN, 1'b1, 13'd7);
      send_uniform(OP_TRAIN, 1'b0, 13'd0);
      send_uniform(OP_TRAIN, 1'b0, 13'd7);
      write_thresholds(20'd655360, 20'd0);
      send_uniform(OP_TRAIN, 1'b1, 13'd0);
      send_uniform(OP_TRAIN, 1'b0, 13'd7);
      send_uniform(OP_TRAIN, 1'b0, 13'd7);
      send_uniform(OP_EVALUATE, 1'b1, 13'd7);
   endtask

   // Mostly training on a small code pool so the tables fill, with some noise
   task automatic test_random(int count);
      logic [12:0] c [TREE_COUNT];
      logic op;
      for (int i = 0; i < count; i++) begin
         foreach (c[t])
            c[t] = ($urandom_range(0, 9) < 8) ? code_pool[t][$urandom_range(0, 7)]
                                                 : 13'($urandom);
         op = ($urandom_range(0, 3) != 0) ? OP_TRAIN : OP_EVALUATE;
         send_item(make_item(op, 1'($urandom), c));
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_votes.size() == 0) begin
            $error("unexpected result vote_sum=%0d", rsp_data.vote_sum);
            error_count++;
         end else begin
            want = expected_votes.pop_front();
            if (rsp_data.vote_sum !== want.vote_sum) begin
               $error("vote_sum expected %0d actual %0d", want.vote_sum, rsp_data.vote_sum);
               error_count++;
            end
            if (rsp_data.did_update !== want.did_update) begin
               $error("did_update expected %0d actual %0d",
                      want.did_update, rsp_data.did_update);
               error_count++;
            end
         end
      end
   end

   // Watchdog: count cycles with no transaction in either direction
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      foreach (code_pool[t, k]) code_pool[t][k] = 13'($urandom);
      foreach (code_pool[t]) begin
         code_pool[t][0] = 13'd0;
         code_pool[t][1] = 13'h1FFF;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      write_thresholds(20'd327680, 20'd327680);
      test_random(350);
      write_thresholds(20'd0, 20'd655360);
      test_random(300);
      write_thresholds(20'd655360, 20'd0);
      test_random(300);
      write_thresholds(20'hFFFFF, 20'hFFFFF);
      test_random(250);
      write_thresholds(20'($urandom_range(0, 655360)), 20'($urandom_range(0, 655360)));
      test_random(300);
      write_thresholds(20'($urandom_range(100000, 400000)), 20'($urandom_range(100000, 400000)));
      test_random(230);
      wait_idle();
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
